### hw/rtl/flmpf_pkg.sv
// Shared types, constants and helpers for the first-local-minimum parabolic fit.
// Used by the front, queue, back, top level and checker; no dependencies.
`default_nettype none

package flmpf_pkg;

   // Field widths
   localparam int DATA_W    = 32;
   localparam int G_W       = 64;
   localparam int INDEX_W   = 10;

   // Longest run; the item at MAX_STEPS-1 closes the run
   localparam int MAX_STEPS = 1024;
   localparam int STEP_W    = $clog2(MAX_STEPS);

   // Depth of the front-to-back job queue
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VMAX       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_WEIGHT = 2'd2;

   localparam logic [DATA_W-1:0] AVG_WEIGHT_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [DATA_W-1:0] vmax;
      logic [DATA_W-1:0] step_size;
      logic [DATA_W-1:0] avg_weight;
   } cfg_type;

   // One finished run handed from the front to the back
   typedef struct packed {
      logic              found;
      logic [STEP_W-1:0] index;
      logic [G_W-1:0]    left;
      logic [G_W-1:0]    mid;
      logic [G_W-1:0]    right;
   } job_type;

   // Magnitude of a signed 32-bit value; the most negative value gives 2^31
   function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
      abs32 = x[DATA_W-1] ? (~x + 32'd1) : x;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/first_local_minimum_parabolic_fit.sv
// Top level of the first-local-minimum parabolic fit: configuration registers,
// front end, job queue and back end. Uses flmpf_pkg and the flmpf_* modules.
//
// The block takes one complex sum per scan step, squares its magnitude and
// finds the first interior step that is no greater than both neighbors; on the
// closing step of a run (last_step, or step MAX_STEPS-1) it gives one result:
// status 0 with the step index and the parabola-refined scan value divided by
// avg_weight (a Q16.16 weight; truncated, saturated), or status 1 with the last
// index and zero. The front end squares the real part of a step as it takes it
// and the imaginary part in its F_SQIM state; the step's compare overlaps the
// next accept, and a closing step waits while the job queue is full. Each run
// then passes the back end's bit-serial fraction and weight dividers; a
// two-entry queue lets the front end go on with the next run meanwhile. A run
// without an interior minimum goes straight to the back end's result state.
`default_nettype none

module first_local_minimum_parabolic_fit
   import flmpf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic signed [DATA_W-1:0] req_sum_real,
   input  wire logic signed [DATA_W-1:0] req_sum_imag,
   input  wire logic                     req_last_step,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output logic                          rsp_status,
   output logic [INDEX_W-1:0]            rsp_min_index,
   output logic signed [DATA_W-1:0]      rsp_v_estimate,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [DATA_W-1:0]        csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   logic              job_push;
   job_type           job_in_data;
   logic              job_full;
   logic              job_pop;
   job_type           job_out_data;
   logic              job_empty;
   logic [DATA_W-1:0] v_estimate;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VMAX:       cfg_in.vmax       = csr_wdata;
            CSR_STEP_SIZE:  cfg_in.step_size  = csr_wdata;
            CSR_AVG_WEIGHT: cfg_in.avg_weight = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vmax       <= '0;
         cfg_ff.step_size  <= '0;
         cfg_ff.avg_weight <= AVG_WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   flmpf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_sum_real  (req_sum_real),
      .req_sum_imag  (req_sum_imag),
      .req_last_step (req_last_step),
      .req_full      (req_full),
      .job_push      (job_push),
      .job_data      (job_in_data),
      .job_full      (job_full)
   );

   flmpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   flmpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .job_data       (job_out_data),
      .job_empty      (job_empty),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_min_index  (rsp_min_index),
      .rsp_v_estimate (v_estimate)
   );

   assign rsp_v_estimate = v_estimate;

endmodule

`default_nettype wire

### hw/rtl/flmpf_front.sv
// Front end: accepts scan steps, squares the real and imaginary parts,
// tracks the first local minimum, emits one job per run. Uses flmpf_pkg.
`default_nettype none

module flmpf_front
   import flmpf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   input  wire logic signed [DATA_W-1:0] req_sum_real,
   input  wire logic signed [DATA_W-1:0] req_sum_imag,
   input  wire logic                     req_last_step,
   output logic                          req_full,
   output logic                          job_push,
   output job_type                       job_data,
   input  wire logic                     job_full
);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS - 1);

   typedef enum logic [1:0] {F_IDLE, F_SQIM, F_UPDATE} state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] im_abs_ff, im_abs_in;
   logic              last_ff, last_in;
   logic [G_W-1:0]    sq_re_ff, sq_re_in;
   logic [G_W-1:0]    sq_im_ff, sq_im_in;
   logic [G_W-1:0]    mag_bp_ff, mag_bp_in;
   logic [G_W-1:0]    mag_p_ff, mag_p_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              found_ff, found_in;
   logic [STEP_W-1:0] found_idx_ff, found_idx_in;
   logic [G_W-1:0]    left_ff, left_in;
   logic [G_W-1:0]    mid_ff, mid_in;
   logic [G_W-1:0]    right_ff, right_in;

   logic [DATA_W-1:0] re_abs;
   logic [G_W-1:0]    mag_new;
   logic              hit;
   logic              run_end;
   logic              upd_go;
   logic              accept;

   always_comb begin
      state_in     = state_ff;
      im_abs_in    = im_abs_ff;
      last_in      = last_ff;
      sq_re_in     = sq_re_ff;
      sq_im_in     = sq_im_ff;
      mag_bp_in    = mag_bp_ff;
      mag_p_in     = mag_p_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      left_in      = left_ff;
      mid_in       = mid_ff;
      right_in     = right_ff;

      // Classify the step whose squares are complete
      mag_new = sq_re_ff + sq_im_ff;
      hit     = !found_ff && (step_ff >= STEP_W'(2)) &&
                (mag_p_ff <= mag_bp_ff) && (mag_p_ff <= mag_new);
      run_end = last_ff || (step_ff == STEP_LAST);
      upd_go  = (state_ff == F_UPDATE) && (!run_end || !job_full);

      // Take a new step when idle or while the current one retires
      req_full = !((state_ff == F_IDLE) || upd_go);
      accept   = req_push && !req_full;

      // Hand the run to the back end on its closing step
      job_push       = upd_go && run_end;
      job_data.found = found_ff || hit;
      job_data.index = found_ff ? found_idx_ff : (hit ? step_ff - STEP_W'(1) : step_ff);
      job_data.left  = found_ff ? left_ff  : mag_bp_ff;
      job_data.mid   = found_ff ? mid_ff   : mag_p_ff;
      job_data.right = found_ff ? right_ff : mag_new;

      re_abs = abs32(req_sum_real);

      unique case (state_ff)
         F_IDLE: begin
         end
         F_SQIM: begin
            sq_im_in = G_W'(im_abs_ff) * G_W'(im_abs_ff);
            state_in = F_UPDATE;
         end
         F_UPDATE: begin
            if (upd_go) begin
               state_in = F_IDLE;
               if (run_end) begin
                  mag_bp_in    = '0;
                  mag_p_in     = '0;
                  step_in      = '0;
                  found_in     = 1'b0;
                  found_idx_in = '0;
                  left_in      = '0;
                  mid_in       = '0;
                  right_in     = '0;
               end else begin
                  if (hit) begin
                     found_in     = 1'b1;
                     found_idx_in = step_ff - STEP_W'(1);
                     left_in      = mag_bp_ff;
                     mid_in       = mag_p_ff;
                     right_in     = mag_new;
                  end
                  mag_bp_in = mag_p_ff;
                  mag_p_in  = mag_new;
                  step_in   = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      // Square the real part straight off the port
      if (accept) begin
         sq_re_in  = G_W'(re_abs) * G_W'(re_abs);
         im_abs_in = abs32(req_sum_imag);
         last_in   = req_last_step;
         state_in  = F_SQIM;
      end
   end

   always_ff @(posedge clock) begin
      im_abs_ff <= im_abs_in;
      last_ff   <= last_in;
      sq_re_ff  <= sq_re_in;
      sq_im_ff  <= sq_im_in;
      if (reset) begin
         state_ff     <= F_IDLE;
         mag_bp_ff    <= '0;
         mag_p_ff     <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         found_idx_ff <= '0;
         left_ff      <= '0;
         mid_ff       <= '0;
         right_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         mag_bp_ff    <= mag_bp_in;
         mag_p_ff     <= mag_p_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         found_idx_ff <= found_idx_in;
         left_ff      <= left_in;
         mid_ff       <= mid_in;
         right_ff     <= right_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/flmpf_queue.sv
// Short job queue between the front and the back end.
// Holds QUEUE_DEPTH jobs of job_type from flmpf_pkg.
`default_nettype none

module flmpf_queue
   import flmpf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_data,
   output logic      full,
   input  wire logic pop,
   output job_type   pop_data,
   output logic      empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      full     = (count_ff == CNT_W'(QUEUE_DEPTH));
      empty    = (count_ff == CNT_W'(0));
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;

      // Advance the pointers with wrap
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/flmpf_back.sv
// Back end: turns one job into the interpolated, weight-scaled estimate with
// bit-serial dividers and a result register. Uses flmpf_pkg.
`default_nettype none

module flmpf_back
   import flmpf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  cfg_type            cfg,
   input  job_type            job_data,
   input  wire logic          job_empty,
   output logic               job_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic               rsp_status,
   output logic [INDEX_W-1:0] rsp_min_index,
   output logic [DATA_W-1:0]  rsp_v_estimate
);

   localparam int FRAC_BITS = 31;
   localparam int PIDX_W    = DATA_W + STEP_W;
   localparam int MAG_W     = 33 + STEP_W;
   localparam int V_W       = MAG_W + 1;
   localparam int DIV_W     = MAG_W + 16;
   localparam int CNT_W     = $clog2(DIV_W + 1);
   localparam int Q_W       = DATA_W + 1;

   typedef enum logic [3:0] {
      B_IDLE, B_PREP, B_DIFF, B_FRAC, B_MULI, B_MULC, B_ROUND, B_SUM, B_ABS, B_DIV, B_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic                 found_ff, found_in;
   logic [STEP_W-1:0]    idx_ff, idx_in;
   logic [G_W-1:0]       left_ff, left_in;
   logic [G_W-1:0]       mid_ff, mid_in;
   logic [G_W-1:0]       right_ff, right_in;
   logic [G_W-1:0]       a_ff, a_in;
   logic [G_W-1:0]       b_ff, b_in;
   logic [G_W:0]         den_ff, den_in;
   logic [G_W-1:0]       num_ff, num_in;
   logic                 up_ff, up_in;
   logic                 flat_ff, flat_in;
   logic [G_W-1:0]       rem_ff, rem_in;
   logic [FRAC_BITS-1:0] fq_ff, fq_in;
   logic [DATA_W-1:0]    f_ff, f_in;
   logic [PIDX_W-1:0]    pidx_ff, pidx_in;
   logic [G_W-1:0]       prod_ff, prod_in;
   logic [DATA_W-1:0]    corr_ff, corr_in;
   logic [V_W-1:0]       v_ff, v_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DATA_W-1:0]    drem_ff, drem_in;
   logic [Q_W-1:0]       dq_ff, dq_in;
   logic                 big_ff, big_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_status_ff, out_status_in;
   logic [INDEX_W-1:0]   out_index_ff, out_index_in;
   logic [DATA_W-1:0]    out_v_ff, out_v_in;

   logic [G_W:0]         rem2;
   logic                 rem_ge;
   logic [DATA_W:0]      drem2;
   logic                 drem_ge;
   logic [G_W-1:0]       round_sum;
   logic [V_W-1:0]       corr_term;
   logic [V_W-1:0]       v_mag;
   logic                 pos_sat;
   logic                 neg_sat;
   logic [DATA_W-1:0]    v_final;
   logic                 out_load;

   always_comb begin
      state_in      = state_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      mid_in        = mid_ff;
      right_in      = right_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      up_in         = up_ff;
      flat_in       = flat_ff;
      rem_in        = rem_ff;
      fq_in         = fq_ff;
      f_in          = f_ff;
      pidx_in       = pidx_ff;
      prod_in       = prod_ff;
      corr_in       = corr_ff;
      v_in          = v_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      dvd_in        = dvd_ff;
      drem_in       = drem_ff;
      dq_in         = dq_ff;
      big_in        = big_ff;
      cnt_in        = cnt_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_v_in      = out_v_ff;

      // Restoring step of the fraction divider
      rem2   = {rem_ff, 1'b0};
      rem_ge = (rem2 >= den_ff);

      // Restoring step of the weight divider
      drem2   = {drem_ff, dvd_ff[DIV_W-1]};
      drem_ge = (drem2 >= {1'b0, cfg.avg_weight});

      round_sum = prod_ff + 64'h0000_0000_8000_0000;
      corr_term = flat_ff ? '0 : (up_ff ? V_W'(corr_ff) : V_W'(0) - V_W'(corr_ff));
      v_mag     = v_ff[V_W-1] ? (V_W'(0) - v_ff) : v_ff;

      // Clamp the quotient to the signed result range
      pos_sat = big_ff || (dq_ff[Q_W-1:Q_W-2] != 2'b00);
      neg_sat = big_ff || (dq_ff > {2'b01, {(Q_W-2){1'b0}}});
      if (zero_ff) begin
         v_final = '0;
      end else if (neg_ff) begin
         v_final = neg_sat ? 32'h8000_0000 : (DATA_W'(0) - dq_ff[DATA_W-1:0]);
      end else begin
         v_final = pos_sat ? 32'h7FFF_FFFF : dq_ff[DATA_W-1:0];
      end

      job_pop  = (state_ff == B_IDLE) && !job_empty;
      out_load = (state_ff == B_DONE) && (!out_valid_ff || rsp_pop);

      // Drop the result once it is taken
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               found_in = job_data.found;
               idx_in   = job_data.index;
               left_in  = job_data.left;
               mid_in   = job_data.mid;
               right_in = job_data.right;
               state_in = job_data.found ? B_PREP : B_DONE;
            end
         end
         B_PREP: begin
            a_in     = left_ff - mid_ff;
            b_in     = right_ff - mid_ff;
            state_in = B_DIFF;
         end
         B_DIFF: begin
            den_in   = {1'b0, a_ff} + {1'b0, b_ff};
            up_in    = (b_ff > a_ff);
            flat_in  = (a_ff == b_ff);
            num_in   = (b_ff > a_ff) ? b_ff - a_ff : a_ff - b_ff;
            rem_in   = (b_ff > a_ff) ? b_ff - a_ff : a_ff - b_ff;
            fq_in    = '0;
            cnt_in   = '0;
            state_in = B_FRAC;
         end
         B_FRAC: begin
            rem_in = rem_ge ? G_W'(rem2 - den_ff) : rem2[G_W-1:0];
            fq_in  = {fq_ff[FRAC_BITS-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               state_in = B_MULI;
            end
         end
         B_MULI: begin
            pidx_in  = PIDX_W'(cfg.step_size) * PIDX_W'(idx_ff);
            // Numerator equal to denominator gives a fraction of one half
            f_in     = ({1'b0, num_ff} == den_ff) ? 32'h8000_0000 : {1'b0, fq_ff};
            state_in = B_MULC;
         end
         B_MULC: begin
            prod_in  = G_W'(cfg.step_size) * G_W'(f_ff);
            state_in = B_ROUND;
         end
         B_ROUND: begin
            corr_in  = round_sum[G_W-1:DATA_W];
            state_in = B_SUM;
         end
         B_SUM: begin
            v_in     = V_W'(cfg.vmax) - V_W'(pidx_ff) + corr_term;
            state_in = B_ABS;
         end
         B_ABS: begin
            neg_in   = v_ff[V_W-1];
            zero_in  = (v_ff == '0);
            dvd_in   = {v_mag[MAG_W-1:0], 16'h0000};
            drem_in  = '0;
            dq_in    = '0;
            big_in   = 1'b0;
            cnt_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            drem_in = drem_ge ? DATA_W'(drem2 - {1'b0, cfg.avg_weight}) : drem2[DATA_W-1:0];
            dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
            dq_in   = {dq_ff[Q_W-2:0], drem_ge};
            big_in  = big_ff || dq_ff[Q_W-1];
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_load) begin
               out_valid_in  = 1'b1;
               out_status_in = !found_ff;
               out_index_in  = INDEX_W'(idx_ff);
               out_v_in      = found_ff ? v_final : '0;
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_empty      = !out_valid_ff;
      rsp_status     = out_status_ff;
      rsp_min_index  = out_index_ff;
      rsp_v_estimate = out_v_ff;
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      mid_ff        <= mid_in;
      right_ff      <= right_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      up_ff         <= up_in;
      flat_ff       <= flat_in;
      rem_ff        <= rem_in;
      fq_ff         <= fq_in;
      f_ff          <= f_in;
      pidx_ff       <= pidx_in;
      prod_ff       <= prod_in;
      corr_ff       <= corr_in;
      v_ff          <= v_in;
      neg_ff        <= neg_in;
      zero_ff       <= zero_in;
      dvd_ff        <= dvd_in;
      drem_ff       <= drem_in;
      dq_ff         <= dq_in;
      big_ff        <= big_in;
      cnt_ff        <= cnt_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_v_ff      <= out_v_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/flmpf_checker.sv
// Port-level checks for the first-local-minimum parabolic fit, bound to the
// top level. Uses flmpf_pkg for field widths.
`default_nettype none

module flmpf_checker
   import flmpf_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_push,
   input wire logic                     req_full,
   input wire logic                     rsp_empty,
   input wire logic                     rsp_pop,
   input wire logic                     rsp_status,
   input wire logic [INDEX_W-1:0]       rsp_min_index,
   input wire logic signed [DATA_W-1:0] rsp_v_estimate
);

   // Come out of reset with no result and open for input
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not empty and ready after reset");

   // Refuse a step in the cycle right after one is taken
   a_squarer_busy: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("step accepted while squarer busy");

   // A run without an interior minimum carries a zero estimate
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status) |-> (rsp_v_estimate == '0))
      else $error("nonzero estimate without a minimum");

   // Hold a waiting result until it is popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_status) && $stable(rsp_min_index) &&
          $stable(rsp_v_estimate)))
      else $error("waiting result changed");

endmodule

bind first_local_minimum_parabolic_fit flmpf_checker u_flmpf_checker (.*);

`default_nettype wire
